>>> rtl/rswr_pkg.sv
package rswr_pkg;

	// Store geometry.
	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int COORD_BITS = 64;
	localparam int WORD_W     = 2 * COORD_BITS;

	// Fixed field widths of the channels.
	localparam int FIELD_W  = 64;
	localparam int RAND_W   = 64;
	localparam int REG_W    = 11;
	localparam int SLOT_W   = 10;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	// Step counter of the bit-serial remainder unit.
	localparam int STEP_W = $clog2(RAND_W + 1);

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DRAW    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNLOADED  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT  = 1'd1;

	localparam logic [REG_W-1:0] POINT_COUNT_RST = 11'd1024;
	localparam logic [REG_W-1:0] PICK_COUNT_RST  = 11'd64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD_POS,
		ST_RD_SLOT,
		ST_WR_SLOT,
		ST_WR_POS,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/rswr_item_if.sv
interface rswr_item_if;
	logic                              valid;
	logic                              ready;
	logic [rswr_pkg::MODE_W-1:0]       mode;
	logic [rswr_pkg::FIELD_W-1:0]      x_word;
	logic [rswr_pkg::FIELD_W-1:0]      y_word;
	logic [rswr_pkg::RAND_W-1:0]       random_word;

	modport source (output valid, mode, x_word, y_word, random_word, input ready);
	modport sink (input valid, mode, x_word, y_word, random_word, output ready);
endinterface

>>> rtl/rswr_result_if.sv
interface rswr_result_if;
	logic                              valid;
	logic                              ready;
	logic [rswr_pkg::FIELD_W-1:0]      pick_x;
	logic [rswr_pkg::FIELD_W-1:0]      pick_y;
	logic [rswr_pkg::SLOT_W-1:0]       pick_slot;
	logic                              last_pick;
	logic [rswr_pkg::STATUS_W-1:0]     status;

	modport source (output valid, pick_x, pick_y, pick_slot, last_pick, status, input ready);
	modport sink (input valid, pick_x, pick_y, pick_slot, last_pick, status, output ready);
endinterface

>>> rtl/rswr_cfg_if.sv
interface rswr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rswr_pkg::CFG_IDX_W-1:0]    index;
	logic [rswr_pkg::REG_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/random_sample_without_replacement_unit.sv
// Draws points without replacement from a store of up to 1024 points (partial
// Fisher-Yates shuffle). A load transfer (mode 0) writes the next point into the
// store unless it is already full; a restart transfer (mode 2) clears the load
// and draw counts; mode 3 is dropped. A draw transfer (mode 1) reduces its random
// word modulo the number of unpicked points with a bit-serial remainder unit
// (one dividend bit per cycle, and then it reports done), then swaps the chosen
// point into the first unpicked slot through the single store memory, which has
// one write and one read port with registered read data: two reads and two
// writes. A draw that reports an error (store not yet loaded, or picks used up)
// skips the remainder unit and the store and goes straight to the result
// register. One item is in work at a time. A result waits in an output register,
// so loads and restarts are taken while it waits, and a following draw stalls
// only in its last cycle.
module random_sample_without_replacement_unit (
	input  logic          clk,
	input  logic          arst_n,
	rswr_item_if.sink     item,
	rswr_result_if.source result,
	rswr_cfg_if.sink      cfg
);

	// Configuration registers and counters.
	logic [rswr_pkg::REG_W-1:0] point_count_q;
	logic [rswr_pkg::REG_W-1:0] pick_count_q;
	logic [rswr_pkg::CNT_W-1:0] loaded_q;
	logic [rswr_pkg::CNT_W-1:0] drawn_q;

	// Draw in flight.
	rswr_pkg::state_t             state_q;
	rswr_pkg::state_t             state_d;
	logic [rswr_pkg::ADDR_W-1:0]  slot_q;
	logic [rswr_pkg::ADDR_W-1:0]  pos_q;
	logic                         last_q;
	logic [rswr_pkg::STATUS_W-1:0] status_q;
	logic [rswr_pkg::WORD_W-1:0]  pos_word_q;
	logic [rswr_pkg::WORD_W-1:0]  slot_word_q;

	// Output register.
	logic                          out_valid_q;
	logic [rswr_pkg::FIELD_W-1:0]  out_x_q;
	logic [rswr_pkg::FIELD_W-1:0]  out_y_q;
	logic [rswr_pkg::SLOT_W-1:0]   out_slot_q;
	logic                          out_last_q;
	logic [rswr_pkg::STATUS_W-1:0] out_status_q;

	// Effective sizes and decisions.
	logic [rswr_pkg::CNT_W-1:0] n_eff;
	logic [rswr_pkg::CNT_W-1:0] picks_eff;
	logic                       in_acc;
	logic                       load_acc;
	logic                       draw_acc;
	logic                       restart_acc;
	logic                       unloaded;
	logic                       exhausted;
	logic                       draw_start;
	logic                       result_load;

	// Memory and remainder unit.
	logic                         ram_we;
	logic [rswr_pkg::ADDR_W-1:0]  ram_waddr;
	logic [rswr_pkg::WORD_W-1:0]  ram_wdata;
	logic [rswr_pkg::ADDR_W-1:0]  ram_raddr;
	logic [rswr_pkg::WORD_W-1:0]  ram_rdata;
	logic                         mod_done;
	logic [rswr_pkg::CNT_W-1:0]   mod_rem;

	// The point count is clamped to the store depth, and the pick count to the
	// clamped point count. Both are taken fresh for every item.
	always_comb begin
		if (32'(point_count_q) > 32'(rswr_pkg::MAX_POINTS)) begin
			n_eff = rswr_pkg::CNT_W'(rswr_pkg::MAX_POINTS);
		end else begin
			n_eff = rswr_pkg::CNT_W'(point_count_q);
		end
		if (32'(pick_count_q) > 32'(n_eff)) begin
			picks_eff = n_eff;
		end else begin
			picks_eff = rswr_pkg::CNT_W'(pick_count_q);
		end
	end

	assign item.ready  = (state_q == rswr_pkg::ST_IDLE);
	assign in_acc      = item.valid && item.ready;
	assign load_acc    = in_acc && (item.mode == rswr_pkg::MODE_LOAD);
	assign draw_acc    = in_acc && (item.mode == rswr_pkg::MODE_DRAW);
	assign restart_acc = in_acc && (item.mode == rswr_pkg::MODE_RESTART);

	// A draw is refused while the store is short of points, and once the
	// configured picks are used up.
	assign unloaded   = loaded_q < n_eff;
	assign exhausted  = drawn_q >= picks_eff;
	assign draw_start = draw_acc && !unloaded && !exhausted;

	// The result register takes a new result when it is empty or being emptied.
	assign result_load = (state_q == rswr_pkg::ST_EMIT) && (!out_valid_q || result.ready);

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= rswr_pkg::POINT_COUNT_RST;
			pick_count_q  <= rswr_pkg::PICK_COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				rswr_pkg::REG_POINT_COUNT: point_count_q <= cfg.data;
				rswr_pkg::REG_PICK_COUNT:  pick_count_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rswr_pkg::ST_IDLE: begin
				if (draw_start) begin
					state_d = rswr_pkg::ST_DIV;
				end else if (draw_acc) begin
					state_d = rswr_pkg::ST_EMIT;
				end
			end
			rswr_pkg::ST_DIV: begin
				if (mod_done) begin
					state_d = rswr_pkg::ST_RD_POS;
				end
			end
			rswr_pkg::ST_RD_POS:  state_d = rswr_pkg::ST_RD_SLOT;
			rswr_pkg::ST_RD_SLOT: state_d = rswr_pkg::ST_WR_SLOT;
			rswr_pkg::ST_WR_SLOT: state_d = rswr_pkg::ST_WR_POS;
			rswr_pkg::ST_WR_POS:  state_d = rswr_pkg::ST_EMIT;
			rswr_pkg::ST_EMIT: begin
				if (result_load) begin
					state_d = rswr_pkg::ST_IDLE;
				end
			end
			default: state_d = rswr_pkg::ST_IDLE;
		endcase
	end

	// Memory controls. Loads write in the idle state; a draw reads the chosen
	// entry, then the first unpicked entry, and writes each into the other's
	// place. When both are the same entry the two writes store the same word.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = loaded_q[rswr_pkg::ADDR_W-1:0];
		ram_wdata = {item.y_word[rswr_pkg::COORD_BITS-1:0],
			item.x_word[rswr_pkg::COORD_BITS-1:0]};
		ram_raddr = pos_q;
		case (state_q)
			rswr_pkg::ST_IDLE: begin
				ram_we = load_acc && unloaded;
			end
			rswr_pkg::ST_RD_SLOT: begin
				ram_raddr = slot_q;
			end
			rswr_pkg::ST_WR_SLOT: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = pos_word_q;
			end
			rswr_pkg::ST_WR_POS: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = slot_word_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rswr_pkg::ST_IDLE;
			loaded_q <= '0;
			drawn_q  <= '0;
		end else begin
			state_q <= state_d;
			if (restart_acc) begin
				loaded_q <= '0;
				drawn_q  <= '0;
			end else if (load_acc && unloaded) begin
				loaded_q <= loaded_q + 1'b1;
			end else if (result_load && (status_q == rswr_pkg::STATUS_OK)) begin
				drawn_q <= drawn_q + 1'b1;
			end
		end
	end

	// Draw context. The remainder is below the unpicked count, so the chosen
	// position stays inside the loaded part of the store.
	always_ff @(posedge clk) begin
		if (draw_acc) begin
			slot_q <= drawn_q[rswr_pkg::ADDR_W-1:0];
			last_q <= (drawn_q + 1'b1) == picks_eff;
			if (unloaded) begin
				status_q <= rswr_pkg::STATUS_UNLOADED;
			end else if (exhausted) begin
				status_q <= rswr_pkg::STATUS_EXHAUSTED;
			end else begin
				status_q <= rswr_pkg::STATUS_OK;
			end
		end
		if ((state_q == rswr_pkg::ST_DIV) && mod_done) begin
			pos_q <= slot_q + mod_rem[rswr_pkg::ADDR_W-1:0];
		end
		if (state_q == rswr_pkg::ST_RD_SLOT) begin
			pos_word_q <= ram_rdata;
		end
		if (state_q == rswr_pkg::ST_WR_SLOT) begin
			slot_word_q <= ram_rdata;
		end
	end

	// Output register. A refused draw gives zeros in every field but status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			out_status_q <= status_q;
			if (status_q == rswr_pkg::STATUS_OK) begin
				out_x_q    <= rswr_pkg::FIELD_W'(pos_word_q[rswr_pkg::COORD_BITS-1:0]);
				out_y_q    <= rswr_pkg::FIELD_W'(
					pos_word_q[rswr_pkg::WORD_W-1:rswr_pkg::COORD_BITS]);
				out_slot_q <= rswr_pkg::SLOT_W'(slot_q);
				out_last_q <= last_q;
			end else begin
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_slot_q <= '0;
				out_last_q <= 1'b0;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.pick_x    = out_x_q;
	assign result.pick_y    = out_y_q;
	assign result.pick_slot = out_slot_q;
	assign result.last_pick = out_last_q;
	assign result.status    = out_status_q;

	rswr_ram #(
		.DATA_W (rswr_pkg::WORD_W),
		.DEPTH  (rswr_pkg::MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The divisor is the number of points not yet picked, at least one here.
	rswr_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (draw_start),
		.dividend (item.random_word),
		.divisor  (n_eff - drawn_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

endmodule

>>> rtl/rswr_ram.sv
module rswr_ram #(
	parameter int DATA_W = 128,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/rswr_mod.sv
// Restoring remainder, one dividend bit per cycle, most significant bit first.
module rswr_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rswr_pkg::RAND_W-1:0] dividend,
	input  logic [rswr_pkg::CNT_W-1:0]  divisor,
	output logic                        done,
	output logic [rswr_pkg::CNT_W-1:0]  rem
);

	logic [rswr_pkg::RAND_W-1:0] div_q;
	logic [rswr_pkg::CNT_W-1:0]  divisor_q;
	logic [rswr_pkg::CNT_W-1:0]  rem_q;
	logic [rswr_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [rswr_pkg::CNT_W:0]    trial;
	logic [rswr_pkg::CNT_W:0]    diff;
	logic [rswr_pkg::CNT_W-1:0]  rem_next;

	always_comb begin
		trial = {rem_q, div_q[rswr_pkg::RAND_W-1]};
		diff  = trial - {1'b0, divisor_q};
		if (trial >= {1'b0, divisor_q}) begin
			rem_next = diff[rswr_pkg::CNT_W-1:0];
		end else begin
			rem_next = trial[rswr_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rswr_pkg::STEP_W'(rswr_pkg::RAND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rswr_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q     <= dividend;
			divisor_q <= divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[rswr_pkg::RAND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> rtl/rswr_checker.sv
module rswr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [rswr_pkg::MODE_W-1:0]   in_mode,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [rswr_pkg::FIELD_W-1:0]  out_x,
	input logic [rswr_pkg::FIELD_W-1:0]  out_y,
	input logic [rswr_pkg::SLOT_W-1:0]   out_slot,
	input logic                          out_last,
	input logic [rswr_pkg::STATUS_W-1:0] out_status
);

	// A waiting result holds its payload until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_slot) && $stable(out_last) && $stable(out_status)))
	else $error("result changed while stalled");

	// A refused draw carries nothing but its status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_status != rswr_pkg::STATUS_OK)) |->
			((out_x == '0) && (out_y == '0) && (out_slot == '0) && !out_last))
	else $error("error result with nonzero fields");

	// Only a draw produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_mode != rswr_pkg::MODE_DRAW)) |=> !$rose(out_valid))
	else $error("result after a non-draw transfer");

	// A draw occupies the block for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_mode == rswr_pkg::MODE_DRAW)) |=> !in_ready)
	else $error("item taken right after a draw");

endmodule

bind random_sample_without_replacement_unit rswr_checker u_rswr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.in_mode    (item.mode),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_x      (result.pick_x),
	.out_y      (result.pick_y),
	.out_slot   (result.pick_slot),
	.out_last   (result.last_pick),
	.out_status (result.status)
);

>>> verif/tb.sv
module tb;
	import rswr_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 5;
	// This pause covers a draw in the block with margin before a register write.
	localparam int SETTLE_CYCLES = 80;
	// How long the result side holds off during the backpressure test.
	localparam int LONG_HOLD     = 600;
	// The longest correct quiet stretch is the long hold plus one draw. This
	// limit is several times that.
	localparam int STALL_LIMIT   = 5000;
	localparam int RANDOM_ITEMS  = 300;
	localparam int QUIET_ITEMS   = 60;
	// Store size for the large store test.
	localparam int LARGE_POINTS  = 256;

	// The package names no code for mode three, which the block must ignore.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [FIELD_W-1:0]  x;
		logic [FIELD_W-1:0]  y;
		logic [SLOT_W-1:0]   slot;
		logic                last;
		logic [STATUS_W-1:0] status;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n;

	rswr_item_if   item_ch ();
	rswr_result_if res_ch ();
	rswr_cfg_if    cfg_ch ();

	random_sample_without_replacement_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// Shadow copy of the point store, the counters and the two registers. It is
	// updated at the clock edge where the block accepts each transfer, so the
	// expected picks line up with what the block sees.
	logic [FIELD_W-1:0] shadow_x [MAX_POINTS];
	logic [FIELD_W-1:0] shadow_y [MAX_POINTS];
	int                 n_loaded;
	int                 n_drawn;
	int                 cfg_points;
	int                 cfg_picks;

	// Picks that the block still owes us, oldest first.
	pick_t pending_picks [$];

	int  n_errors;
	int  n_sent;
	int  n_loads;
	int  n_ok;
	int  n_last;
	int  n_exhausted;
	int  n_unloaded;
	int  n_writes;
	bit  idle_on;
	bit  hold_request;
	int  quiet_cycles;

	// The effective store size is the point count clipped to the store depth,
	// and the effective pick count is clipped to that size.
	function automatic int live_points();
		return (cfg_points > MAX_POINTS) ? MAX_POINTS : cfg_points;
	endfunction

	function automatic int live_picks(int n);
		return (cfg_picks > n) ? n : cfg_picks;
	endfunction

	// One step of the partial shuffle for an accepted item. Only a draw owes a
	// result; loads, restarts and mode three produce nothing.
	function automatic void shuffle_step(logic [MODE_W-1:0] md, logic [FIELD_W-1:0] xw,
			logic [FIELD_W-1:0] yw, logic [RAND_W-1:0] rw);
		int                 n;
		int                 picks;
		int                 slot;
		int                 pos;
		logic [RAND_W-1:0]  left;
		logic [FIELD_W-1:0] tx;
		logic [FIELD_W-1:0] ty;
		pick_t              p;

		n = live_points();
		picks = live_picks(n);
		case (md)
			MODE_LOAD: begin
				// A load into a full store is dropped.
				if (n_loaded < n) begin
					shadow_x[n_loaded] = xw;
					shadow_y[n_loaded] = yw;
					n_loaded++;
					n_loads++;
				end
			end
			MODE_RESTART: begin
				// The store keeps its contents, but it must be loaded again.
				n_loaded = 0;
				n_drawn = 0;
			end
			MODE_DRAW: begin
				p = '0;
				if (n_loaded < n) begin
					p.status = STATUS_UNLOADED;
					n_unloaded++;
				end else if (n_drawn >= picks) begin
					// This also covers an empty store, where no pick is possible.
					p.status = STATUS_EXHAUSTED;
					n_exhausted++;
				end else begin
					// Plain modulo over the unpicked points, bias included, then
					// swap the chosen point into the first unpicked slot.
					slot = n_drawn;
					left = RAND_W'(n - slot);
					pos = slot + int'(rw % left);
					tx = shadow_x[slot];
					ty = shadow_y[slot];
					shadow_x[slot] = shadow_x[pos];
					shadow_y[slot] = shadow_y[pos];
					shadow_x[pos] = tx;
					shadow_y[pos] = ty;
					p.x = shadow_x[slot];
					p.y = shadow_y[slot];
					p.slot = SLOT_W'(slot);
					p.last = (slot + 1 == picks);
					p.status = STATUS_OK;
					n_drawn = slot + 1;
					n_ok++;
					if (p.last)
						n_last++;
				end
				pending_picks.push_back(p);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random words lean toward the extremes now and then, so that both small words
	// and the all-ones word come up often.
	function automatic logic [RAND_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return RAND_W'($urandom_range(0, 1023));
			default: return rand64();
		endcase
	endfunction

	task automatic field_check(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			n_errors++;
		end
	endtask

	task automatic check_pick();
		pick_t want;

		if (pending_picks.size() == 0) begin
			$display("%0t: result with nothing expected, actual x=%h y=%h slot=%0d last=%0b st=%0d",
				$time, res_ch.pick_x, res_ch.pick_y, res_ch.pick_slot, res_ch.last_pick,
				res_ch.status);
			n_errors++;
		end else begin
			want = pending_picks.pop_front();
			field_check("pick_x", want.x, res_ch.pick_x);
			field_check("pick_y", want.y, res_ch.pick_y);
			field_check("pick_slot", 64'(want.slot), 64'(res_ch.pick_slot));
			field_check("last_pick", 64'(want.last), 64'(res_ch.last_pick));
			field_check("status", 64'(want.status), 64'(res_ch.status));
		end
	endtask

	// Offers one item and returns at the edge where it is transferred. Valid is
	// left high so the next item can follow without a bubble; whoever comes next
	// either drives a new item or lowers valid in the same time step.
	task automatic send_item(logic [MODE_W-1:0] md, logic [FIELD_W-1:0] xw,
			logic [FIELD_W-1:0] yw, logic [RAND_W-1:0] rw);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= md;
		item_ch.x_word <= xw;
		item_ch.y_word <= yw;
		item_ch.random_word <= rw;
		do @(posedge clk); while (!item_ch.ready);
		shuffle_step(md, xw, yw, rw);
		n_sent++;
	endtask

	task automatic load_point(logic [FIELD_W-1:0] xw, logic [FIELD_W-1:0] yw);
		send_item(MODE_LOAD, xw, yw, rand64());
	endtask

	task automatic draw_point(logic [RAND_W-1:0] rw);
		send_item(MODE_DRAW, rand64(), rand64(), rw);
	endtask

	task automatic restart_counts();
		send_item(MODE_RESTART, rand64(), rand64(), rand64());
	endtask

	// Something other than the next step of a well-formed sequence.
	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_item(MODE_UNUSED, rand64(), rand64(), rand64());
			1: draw_point(rand_word());
			2: restart_counts();
			default: load_point(rand64(), rand64());
		endcase
	endtask

	// Stops offering items and waits until every owed pick has come back, then
	// gives the block time to finish a trailing load or restart.
	task automatic settle_block();
		item_ch.valid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
		settle_block();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_POINT_COUNT)
			cfg_points = val;
		else
			cfg_picks = val;
		n_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	// Right after reset the store counts as empty, so a draw must report that
	// loading is not complete. Mode three and a restart are also tried here.
	task automatic test_draw_before_load();
		draw_point('1);
		send_item(MODE_UNUSED, '1, '1, '1);
		load_point('1, '1);
		restart_counts();
		draw_point('0);
	endtask

	// With a point count of zero loading is complete at once and every draw
	// reports the picks as used up, whatever the pick count says.
	task automatic test_empty_store();
		write_reg(REG_POINT_COUNT, '0);
		write_reg(REG_PICK_COUNT, '0);
		draw_point(rand_word());
		load_point(rand64(), rand64());
		draw_point('1);
		write_reg(REG_PICK_COUNT, '1);
		draw_point(rand_word());
	endtask

	// One point: a single pick that is also the last, then exhaustion, a load
	// into the full store, and a restart that forces a reload.
	task automatic test_single_point();
		write_reg(REG_POINT_COUNT, REG_W'(1));
		write_reg(REG_PICK_COUNT, REG_W'(1));
		restart_counts();
		load_point('1, '0);
		draw_point('1);
		draw_point(rand_word());
		load_point(rand64(), rand64());
		restart_counts();
		draw_point(rand_word());
		load_point('0, '1);
		draw_point('0);
	endtask

	// Two points, where the first draw takes the second point, so the swap
	// moves the first point up and the second draw must return it.
	task automatic test_swap();
		write_reg(REG_POINT_COUNT, REG_W'(2));
		write_reg(REG_PICK_COUNT, REG_W'(2));
		restart_counts();
		load_point(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		load_point(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		draw_point(RAND_W'(1));
		draw_point(RAND_W'(5));
		draw_point(rand_word());
	endtask

	// A large store with a pick count above its size, then a pick count cut
	// down in the middle of the run so the picks end early, and last a point
	// count beyond the store depth, which asks for more loading.
	task automatic test_large_store();
		write_reg(REG_POINT_COUNT, REG_W'(LARGE_POINTS));
		write_reg(REG_PICK_COUNT, '1);
		restart_counts();
		while (n_loaded < live_points())
			load_point(rand64(), rand64());
		load_point(rand64(), rand64());
		draw_point('1);
		draw_point('0);
		repeat (8) draw_point(rand_word());
		write_reg(REG_PICK_COUNT, REG_W'(12));
		repeat (4) draw_point(rand_word());
		write_reg(REG_POINT_COUNT, '1);
		draw_point(rand_word());
	endtask

	// The result side holds off for a long stretch while draws keep coming, so
	// one result waits in the block and the next draw stalls the item channel.
	task automatic test_backpressure();
		write_reg(REG_POINT_COUNT, REG_W'(8));
		write_reg(REG_PICK_COUNT, REG_W'(8));
		restart_counts();
		while (n_loaded < live_points())
			load_point(rand64(), rand64());
		hold_request = 1'b1;
		repeat (10) begin
			draw_point(rand_word());
			load_point(rand64(), rand64());
		end
	endtask

	// One random round: registers, restart, a full load, the configured draws
	// and a couple more, with noise mixed in. Sometimes the point count then
	// grows, which forces a further load before the next picks.
	task automatic run_round();
		int pts;
		int pk;

		case ($urandom_range(0, 15))
			0: pts = 0;
			1: pts = $urandom_range(17, 48);
			default: pts = $urandom_range(1, 16);
		endcase
		case ($urandom_range(0, 9))
			0: pk = 0;
			1: pk = $urandom_range(MAX_POINTS, 2047);
			default: pk = $urandom_range(1, pts + 1);
		endcase
		if ($urandom_range(0, 1)) begin
			write_reg(REG_POINT_COUNT, REG_W'(pts));
			write_reg(REG_PICK_COUNT, REG_W'(pk));
		end else begin
			write_reg(REG_PICK_COUNT, REG_W'(pk));
			write_reg(REG_POINT_COUNT, REG_W'(pts));
		end
		restart_counts();
		while (n_loaded < live_points()) begin
			if ($urandom_range(0, 11) == 0)
				send_noise();
			else
				load_point(rand64(), rand64());
		end
		if ($urandom_range(0, 2) == 0)
			load_point(rand64(), rand64());
		repeat (live_picks(live_points()) + $urandom_range(0, 2)) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			else
				draw_point(rand_word());
		end
		if ($urandom_range(0, 5) == 0) begin
			write_reg(REG_POINT_COUNT, REG_W'(pts + $urandom_range(1, 4)));
			draw_point(rand_word());
			while (n_loaded < live_points())
				load_point(rand64(), rand64());
			repeat (2) draw_point(rand_word());
		end
	endtask

	task automatic test_random(int items);
		int goal;

		goal = n_sent + items;
		while (n_sent < goal)
			run_round();
	endtask

	// Result side: checks each transfer against the oldest owed pick and
	// drives ready, with short random stalls and the one long hold.
	initial begin
		int stall_left;

		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				check_pick();
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD - 1;
				res_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 6);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a long stretch with no transfer on any channel means the block
	// has hung.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d picks still owed", $time,
				quiet_cycles, pending_picks.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		n_loaded = 0;
		n_drawn = 0;
		cfg_points = POINT_COUNT_RST;
		cfg_picks = PICK_COUNT_RST;
		n_errors = 0;
		n_sent = 0;
		n_loads = 0;
		n_ok = 0;
		n_last = 0;
		n_exhausted = 0;
		n_unloaded = 0;
		n_writes = 0;
		idle_on = 1'b1;
		hold_request = 1'b0;

		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.mode <= MODE_LOAD;
		item_ch.x_word <= '0;
		item_ch.y_word <= '0;
		item_ch.random_word <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_POINT_COUNT;
		cfg_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_draw_before_load();
		test_empty_store();
		test_single_point();
		test_swap();
		test_large_store();
		test_backpressure();
		test_random(RANDOM_ITEMS);
		// The closing stretch runs with both sides streaming at full rate.
		idle_on = 1'b0;
		test_random(QUIET_ITEMS);

		settle_block();
		$display("Sent %0d items: %0d points loaded, %0d good picks (%0d closing a run).",
			n_sent, n_loads, n_ok, n_last);
		$display("Also %0d used-up and %0d not-loaded reports, over %0d register writes.",
			n_exhausted, n_unloaded, n_writes);
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/rswr_pkg.sv
rtl/rswr_item_if.sv
rtl/rswr_result_if.sv
rtl/rswr_cfg_if.sv
rtl/rswr_ram.sv
rtl/rswr_mod.sv
rtl/random_sample_without_replacement_unit.sv
rtl/rswr_checker.sv
verif/tb.sv
